/* hdl/bbrd_pkg.sv */
// Shared types and constants for the blocked billing record deframer.
// Used by bbrd_core and the top level blocked_billing_record_deframer.
package bbrd_pkg;

    // Block framing
    localparam int BLOCK_BYTES   = 2048;
    localparam int HEADER_BYTES  = 20;
    localparam int LENGTH_OFFSET = 13;

    localparam int POS_W  = $clog2(BLOCK_BYTES);   // position inside a block
    localparam int PAD_W  = POS_W + 1;             // padding count, holds a whole block
    localparam int USED_W = 16;                    // used length field from the header

    // Reset values of the record length registers
    localparam logic [7:0] LEN_ZERO_RST  = 8'd60;
    localparam logic [7:0] LEN_ONE_RST   = 8'd78;
    localparam logic [7:0] LEN_THREE_RST = 8'd160;
    localparam logic [7:0] LEN_FOUR_RST  = 8'd106;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_LEN_ZERO  = 2'd0,
        CFG_LEN_ONE   = 2'd1,
        CFG_LEN_THREE = 2'd2,
        CFG_LEN_FOUR  = 2'd3
    } cfg_index_t;

    // Known record type nibbles
    localparam logic [3:0] TYPE_ZERO  = 4'h0;
    localparam logic [3:0] TYPE_ONE   = 4'h1;
    localparam logic [3:0] TYPE_THREE = 4'h3;
    localparam logic [3:0] TYPE_FOUR  = 4'h4;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_RECORD = 3'b010,
        PH_PAD    = 3'b100
    } phase_t;

    typedef enum logic [2:0] {
        WHY_RUN    = 3'd0,
        WHY_ZERO   = 3'd1,
        WHY_LENGTH = 3'd2,
        WHY_TYPE   = 3'd3,
        WHY_TRUNC  = 3'd4,
        WHY_CLEAN  = 3'd5
    } reason_t;

    typedef struct packed {
        logic [7:0] len_zero;
        logic [7:0] len_one;
        logic [7:0] len_three;
        logic [7:0] len_four;
    } len_set_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       rec;
        logic       first;
        logic       last;
        logic       ok;
        logic [3:0] typ;
        logic       done;
        reason_t    why;
    } res_t;

    typedef struct packed {
        logic stopped;
    } stat_t;

endpackage

/* hdl/bbrd_core.sv */
// Per-byte framing state and tagging logic of the deframer.
// Depends on bbrd_pkg; one step per accepted byte, result is combinational.
module bbrd_core
    import bbrd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] in_byte,
    input  logic       file_end,
    input  len_set_t   lens,
    output res_t       res,
    output stat_t      stat
);

    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(BLOCK_BYTES - 1);
    localparam logic [POS_W-1:0] POS_LEN_HI = POS_W'(LENGTH_OFFSET);
    localparam logic [POS_W-1:0] POS_LEN_LO = POS_W'(LENGTH_OFFSET + 1);
    localparam logic [POS_W-1:0] POS_HDR    = POS_W'(HEADER_BYTES);
    localparam logic [PAD_W-1:0] BLOCK_LEN  = PAD_W'(BLOCK_BYTES);
    localparam logic [USED_W-1:0] USED_MAX  = USED_W'(BLOCK_BYTES);

    logic [POS_W-1:0]  pos_reg, pos_next;
    phase_t            phase_reg, phase_next;
    logic [USED_W-1:0] used_reg, used_next;
    logic [PAD_W-1:0]  pad_reg, pad_next;
    logic [7:0]        left_reg, left_next;
    logic              nz_reg, nz_next;
    logic [3:0]        type_reg, type_next;
    reason_t           why_reg, why_next;

    logic [POS_W-1:0]  pos_adv;
    logic [3:0]        nib;
    logic [7:0]        type_len;
    logic              type_known;
    logic              is_first;
    logic [7:0]        left_dec;
    logic              nz_upd;
    logic [PAD_W-1:0]  pad_dec;

    assign pos_adv  = (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
    assign nib      = in_byte[7:4];
    assign is_first = (left_reg == 8'd0);
    assign left_dec = (is_first ? type_len : left_reg) - 8'd1;
    assign nz_upd   = (is_first ? 1'b0 : nz_reg) | (in_byte != 8'd0);
    assign pad_dec  = (pad_reg != '0) ? pad_reg - 1'b1 : '0;

    always_comb
    begin
        type_len   = 8'd0;
        type_known = 1'b1;
        unique case (nib)
            TYPE_ZERO:  type_len = lens.len_zero;
            TYPE_ONE:   type_len = lens.len_one;
            TYPE_THREE: type_len = lens.len_three;
            TYPE_FOUR:  type_len = lens.len_four;
            default:    type_known = 1'b0;
        endcase
    end

    always_comb
    begin
        pos_next   = pos_reg;
        phase_next = phase_reg;
        used_next  = used_reg;
        pad_next   = pad_reg;
        left_next  = left_reg;
        nz_next    = nz_reg;
        type_next  = type_reg;
        why_next   = why_reg;

        res          = '0;
        res.out_byte = in_byte;

        if (why_reg == WHY_RUN)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (pos_reg == POS_LEN_HI)
                        used_next = {in_byte, 8'h00};
                    if (pos_reg == POS_LEN_LO)
                    begin
                        used_next = {used_reg[15:8], in_byte};
                        if ({used_reg[15:8], in_byte} > USED_MAX)
                            why_next = WHY_LENGTH;
                    end
                    pos_next = pos_adv;
                    if (pos_adv == POS_HDR)
                        phase_next = PH_RECORD;
                    if (file_end && why_next == WHY_RUN)
                        why_next = WHY_CLEAN;
                end
                PH_PAD:
                begin
                    pos_next = pos_adv;
                    pad_next = pad_dec;
                    if (pad_dec == '0)
                        phase_next = (pos_adv == '0) ? PH_HEADER : PH_RECORD;
                    if (file_end)
                        why_next = WHY_CLEAN;
                end
                default:
                begin
                    if (is_first && !type_known)
                    begin
                        why_next = WHY_TYPE;
                        res.typ  = nib;
                    end
                    else if (is_first && type_len == 8'd0)
                    begin
                        why_next = WHY_ZERO;
                    end
                    else
                    begin
                        res.rec   = 1'b1;
                        res.first = is_first;
                        res.typ   = is_first ? nib : type_reg;
                        type_next = is_first ? nib : type_reg;
                        nz_next   = nz_upd;
                        left_next = left_dec;
                        pos_next  = pos_adv;
                        if (left_dec == 8'd0)
                        begin
                            res.last = 1'b1;
                            res.ok   = nz_upd;
                            if (!nz_upd)
                                why_next = WHY_ZERO;
                            else
                            begin
                                // used length mod block size is a plain mask
                                if (pos_adv == used_reg[POS_W-1:0]
                                    && used_reg[PAD_W-1:0] != BLOCK_LEN)
                                begin
                                    phase_next = PH_PAD;
                                    pad_next   = BLOCK_LEN - used_reg[PAD_W-1:0];
                                end
                                else
                                    phase_next = (pos_adv == '0) ? PH_HEADER : PH_RECORD;
                                if (file_end)
                                    why_next = WHY_CLEAN;
                            end
                        end
                        else if (file_end)
                        begin
                            res.last = 1'b1;
                            why_next = WHY_TRUNC;
                        end
                    end
                end
            endcase
        end

        res.why  = why_next;
        res.done = (why_next != WHY_RUN);
    end

    assign stat.stopped = (why_reg != WHY_RUN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            phase_reg <= PH_HEADER;
            used_reg  <= '0;
            pad_reg   <= '0;
            left_reg  <= '0;
            nz_reg    <= 1'b0;
            type_reg  <= '0;
            why_reg   <= WHY_RUN;
        end
        else if (step)
        begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            used_reg  <= used_next;
            pad_reg   <= pad_next;
            left_reg  <= left_next;
            nz_reg    <= nz_next;
            type_reg  <= type_next;
            why_reg   <= why_next;
        end
    end

endmodule

/* hdl/blocked_billing_record_deframer.sv */
// Top level of the blocked billing record deframer: stream handshake,
// input and result registers, record length registers.
// Depends on bbrd_pkg and bbrd_core.
//
//  channel | direction | payload
//  --------+-----------+-----------------------------------------------------
//  s_*     | in        | tdata: in_byte; tlast: file_end
//  m_*     | out       | tdata: out_byte; tlast: record_last; tuser: flags/type
//  cfg_*   | in        | write enable, register index (0..3), 8-bit length
//
// One byte per cycle sustained while the output is not stalled; each byte goes
// through the input register and then the result register, and a stall can hold it between them.
// All framing state updates once per byte in bbrd_core.
// Reset clears the framing state and loads the default record lengths.
// A stalled result holds; the input register still fills behind it.
module blocked_billing_record_deframer
    import bbrd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic [10:0] m_tuser,    // [0] record_byte, [1] record_first, [2] record_ok,
                                    // [6:3] record_type, [7] stream_done, [10:8] end_reason
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    len_set_t   lens_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg;
    res_t       out_res_reg;
    res_t       core_res;
    stat_t      core_stat;
    logic       advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lens_reg.len_zero  <= LEN_ZERO_RST;
            lens_reg.len_one   <= LEN_ONE_RST;
            lens_reg.len_three <= LEN_THREE_RST;
            lens_reg.len_four  <= LEN_FOUR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_LEN_ZERO:  lens_reg.len_zero  <= cfg_data;
                CFG_LEN_ONE:   lens_reg.len_one   <= cfg_data;
                CFG_LEN_THREE: lens_reg.len_three <= cfg_data;
                CFG_LEN_FOUR:  lens_reg.len_four  <= cfg_data;
                default:       lens_reg <= lens_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance)
            out_res_reg <= core_res;
    end

    bbrd_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .in_byte  (in_byte_reg),
        .file_end (in_last_reg),
        .lens     (lens_reg),
        .res      (core_res),
        .stat     (core_stat)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg.out_byte;
    assign m_tlast  = out_res_reg.last;
    assign m_tuser  = {out_res_reg.why, out_res_reg.done, out_res_reg.typ,
                       out_res_reg.ok, out_res_reg.first, out_res_reg.rec};

    // Once stopped, parsing never resumes.
    assert property (@(posedge clk) disable iff (!rst_n)
        core_stat.stopped |=> core_stat.stopped)
        else $error("deframer resumed after stop");

    // A record end always belongs to a record.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("record_last on a non-record byte");

    // ok is only shown on the last byte of a record.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |-> m_tlast)
        else $error("record_ok without record_last");

    // A first byte is a record byte of a running or just-stopping stream.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("record_first on a non-record byte");

endmodule
